[rtl/slil_pkg.sv]
package slil_pkg;

  localparam int COUNT_W = 5;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_DELETE = 2'd1;
  localparam logic [1:0] REQ_READ   = 2'd2;

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_BAD_POS   = 2'd3;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [31:0] value;
    logic [3:0]         position;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [COUNT_W-1:0] count;
    logic signed [31:0] read_value;
  } rsp_t;

  // shift control broadcast to every cell
  typedef struct packed {
    logic ins;
    logic del;
  } ctl_t;

endpackage

[rtl/slil_cell.sv]
module slil_cell (
  input  logic                clk,
  input  slil_pkg::ctl_t      ctl,
  input  logic                occ,
  input  logic signed [31:0]  v,
  input  logic                left_lt,
  input  logic signed [31:0]  left_val,
  input  logic signed [31:0]  right_val,
  output logic                lt,
  output logic                hit,
  output logic signed [31:0]  val
);
  import slil_pkg::*;

  logic signed [31:0] val_next;

  assign lt  = occ && (val < v);
  assign hit = occ && left_lt && !lt && (val == v);

  always_comb begin
    val_next = val;
    if (ctl.ins && !lt) begin
      val_next = left_lt ? v : left_val;
    end else if (ctl.del && !lt) begin
      val_next = right_val;
    end
  end

  always_ff @(posedge clk) begin
    val <= val_next;
  end

endmodule

[rtl/sorted_list_insert_delete_top.sv]
// Sorted list, one compare-and-shift cell per entry.
// The response is registered in the cycle after a request is accepted.
// Throughput: 1 request per cycle while the response is not stalled; every cell compares and shifts in the same cycle.
// A stalled response holds the request side off until it is taken.
// Reset (rst, synchronous): count and response valid cleared; cell contents not reset.
module sorted_list_insert_delete_top #(
  parameter int DEPTH = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  slil_pkg::req_t req,
  input  logic          req_valid,
  output logic          req_stall,
  output slil_pkg::rsp_t rsp,
  output logic          rsp_valid,
  input  logic          rsp_stall
);
  import slil_pkg::*;

  localparam int CW  = $clog2(DEPTH + 1);
  localparam int RDN = (DEPTH < 16) ? DEPTH : 16;

  logic [CW-1:0]      cnt;
  logic [CW-1:0]      cnt_next;
  logic               accept;
  logic               full;
  logic               found;
  ctl_t               ctl;
  rsp_t               rsp_next;
  logic signed [31:0] rd_val;
  logic               pos_ok;

  logic signed [31:0] vals [DEPTH];
  logic [DEPTH-1:0]   lt;
  logic [DEPTH-1:0]   hit;
  logic [DEPTH-1:0]   occ;

  assign req_stall = rsp_valid && rsp_stall;
  assign accept    = req_valid && !req_stall;
  assign full      = (cnt == CW'(DEPTH));
  assign found     = |hit;

  assign ctl.ins = accept && (req.req_type == REQ_INSERT) && !full;
  assign ctl.del = accept && (req.req_type == REQ_DELETE) && found;

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      assign occ[g] = (CW'(g) < cnt);
      slil_cell u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .occ       (occ[g]),
        .v         (req.value),
        .left_lt   ((g == 0) ? 1'b1 : lt[(g == 0) ? 0 : g - 1]),
        .left_val  (vals[(g == 0) ? 0 : g - 1]),
        .right_val (vals[(g == DEPTH - 1) ? g : g + 1]),
        .lt        (lt[g]),
        .hit       (hit[g]),
        .val       (vals[g])
      );
    end
  endgenerate

  always_comb begin
    rd_val = '0;
    for (int k = 0; k < RDN; k++) begin
      if (req.position == 4'(k)) begin
        rd_val = vals[k];
      end
    end
  end

  assign pos_ok = (32'(req.position) < 32'(cnt)) && (32'(req.position) < DEPTH);

  always_comb begin
    cnt_next            = cnt;
    rsp_next.status     = ST_DONE;
    rsp_next.read_value = '0;
    case (req.req_type)
      REQ_INSERT: begin
        if (full) begin
          rsp_next.status = ST_FULL;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      REQ_DELETE: begin
        if (found) begin
          cnt_next = cnt - 1'b1;
        end else begin
          rsp_next.status = ST_NOT_FOUND;
        end
      end
      REQ_READ: begin
        if (pos_ok) begin
          rsp_next.read_value = rd_val;
        end else begin
          rsp_next.status = ST_BAD_POS;
        end
      end
      default: begin
      end
    endcase
    rsp_next.count = COUNT_W'(cnt_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        cnt       <= cnt_next;
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= rsp_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst) cnt <= CW'(DEPTH))
    else $error("count above depth");

  assert property (@(posedge clk) disable iff (rst) ctl.ins |=> cnt == $past(cnt) + 1'b1)
    else $error("insert did not grow count");

  assert property (@(posedge clk) disable iff (rst) ctl.del |=> cnt == $past(cnt) - 1'b1)
    else $error("delete did not shrink count");

  assert property (@(posedge clk) disable iff (rst) $onehot0(hit))
    else $error("more than one delete slot");

  assert property (@(posedge clk) disable iff (rst) accept |=> rsp_valid && rsp.count == COUNT_W'(cnt))
    else $error("response count mismatch");

endmodule
